// ----- rtl/cra_pkg.sv -----
package cra_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] IDX_H = 3'd4;
    localparam logic [2:0] IDX_L = 3'd5;
    localparam logic [2:0] IDX_M = 3'd6;
    localparam logic [2:0] IDX_A = 3'd7;

    localparam logic [2:0] SRC_INC = 3'b100;
    localparam logic [2:0] SRC_DEC = 3'b101;

    localparam logic [7:0] OP_HALT = 8'h76;

    localparam logic [2:0] K_LD   = 3'd0;
    localparam logic [2:0] K_ALU  = 3'd1;
    localparam logic [2:0] K_INC  = 3'd2;
    localparam logic [2:0] K_DEC  = 3'd3;
    localparam logic [2:0] K_NONE = 3'd4;

    localparam logic [2:0] ALU_ADD = 3'd0;
    localparam logic [2:0] ALU_ADC = 3'd1;
    localparam logic [2:0] ALU_SUB = 3'd2;
    localparam logic [2:0] ALU_SBC = 3'd3;
    localparam logic [2:0] ALU_AND = 3'd4;
    localparam logic [2:0] ALU_XOR = 3'd5;
    localparam logic [2:0] ALU_OR  = 3'd6;
    localparam logic [2:0] ALU_CP  = 3'd7;

    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    typedef struct packed {
        logic [7:0] opcode;
        logic [7:0] mem_data;
    } t_in;

    typedef struct packed {
        logic [15:0] hl_address;
        logic        mem_write;
        logic [7:0]  mem_write_data;
        logic [7:0]  accumulator;
        logic [3:0]  flags_out;
        logic        unsupported;
    } t_out;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] dst;
        logic [2:0] src;
        logic [7:0] mem_data;
    } t_uop;

endpackage

// ----- rtl/cra_decode.sv -----
module cra_decode (
    input  cra_pkg::t_in  i_beat,
    output cra_pkg::t_uop o_uop
);

    logic [7:0] op;

    assign op = i_beat.opcode;

    always_comb begin
        o_uop.dst      = op[5:3];
        o_uop.src      = op[2:0];
        o_uop.mem_data = i_beat.mem_data;
        unique case (op[7:6])
            2'b01: begin
                o_uop.kind = (op == cra_pkg::OP_HALT) ? cra_pkg::K_NONE : cra_pkg::K_LD;
            end
            2'b10: begin
                o_uop.kind = cra_pkg::K_ALU;
            end
            2'b00: begin
                if (op[2:0] == cra_pkg::SRC_INC) begin
                    o_uop.kind = cra_pkg::K_INC;
                end else if (op[2:0] == cra_pkg::SRC_DEC) begin
                    o_uop.kind = cra_pkg::K_DEC;
                end else begin
                    o_uop.kind = cra_pkg::K_NONE;
                end
            end
            default: begin
                o_uop.kind = cra_pkg::K_NONE;
            end
        endcase
    end

endmodule

// ----- rtl/cra_fifo.sv -----
module cra_fifo #(
    parameter int DEPTH = cra_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cra_pkg::t_uop i_uop,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output cra_pkg::t_uop o_uop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    cra_pkg::t_uop r_mem [0:DEPTH-1];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == FULL);
    assign o_valid = (r_count != '0);
    assign o_uop   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_uop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ----- rtl/cra_exec.sv -----
module cra_exec (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_uop_valid,
    input  cra_pkg::t_uop i_uop,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output cra_pkg::t_out o_data
);

    logic [7:0]    r_regs [0:7];
    logic [3:0]    r_flags;
    logic          r_out_valid;
    cra_pkg::t_out r_out;
    cra_pkg::t_out n_out;

    logic [2:0] rd_idx;
    logic [7:0] opnd, a, alu_res, inc_val, dec_val;
    logic       cin, cin_add, cin_sub;
    logic [8:0] sum9, dif9;
    logic [4:0] sum5, dif5;
    logic       wr_reg, wr_flags, mem_wr, unsup;
    logic [2:0] wr_idx;
    logic [7:0] wr_val, mem_wdata;
    logic [3:0] new_flags;

    assign a       = r_regs[cra_pkg::IDX_A];
    assign cin     = r_flags[cra_pkg::FLAG_C];
    assign rd_idx  = (i_uop.kind == cra_pkg::K_INC || i_uop.kind == cra_pkg::K_DEC)
                     ? i_uop.dst : i_uop.src;
    assign opnd    = (rd_idx == cra_pkg::IDX_M) ? i_uop.mem_data : r_regs[rd_idx];
    assign cin_add = (i_uop.dst == cra_pkg::ALU_ADC) && cin;
    assign cin_sub = (i_uop.dst == cra_pkg::ALU_SBC) && cin;
    assign sum9    = {1'b0, a} + {1'b0, opnd} + {8'd0, cin_add};
    assign sum5    = {1'b0, a[3:0]} + {1'b0, opnd[3:0]} + {4'd0, cin_add};
    assign dif9    = {1'b0, a} - {1'b0, opnd} - {8'd0, cin_sub};
    assign dif5    = {1'b0, a[3:0]} - {1'b0, opnd[3:0]} - {4'd0, cin_sub};
    assign inc_val = opnd + 8'd1;
    assign dec_val = opnd - 8'd1;

    always_comb begin
        wr_reg    = 1'b0;
        wr_idx    = i_uop.dst;
        wr_val    = opnd;
        wr_flags  = 1'b0;
        new_flags = r_flags;
        mem_wr    = 1'b0;
        mem_wdata = opnd;
        unsup     = 1'b0;
        alu_res   = sum9[7:0];
        unique case (i_uop.kind)
            cra_pkg::K_LD: begin
                mem_wr = (i_uop.dst == cra_pkg::IDX_M);
                wr_reg = !mem_wr;
            end
            cra_pkg::K_ALU: begin
                wr_flags = 1'b1;
                wr_idx   = cra_pkg::IDX_A;
                wr_reg   = (i_uop.dst != cra_pkg::ALU_CP);
                case (i_uop.dst) inside
                    cra_pkg::ALU_ADD, cra_pkg::ALU_ADC: begin
                        alu_res   = sum9[7:0];
                        new_flags = {sum9[7:0] == 8'd0, 1'b0, sum5[4], sum9[8]};
                    end
                    cra_pkg::ALU_SUB, cra_pkg::ALU_SBC, cra_pkg::ALU_CP: begin
                        alu_res   = dif9[7:0];
                        new_flags = {dif9[7:0] == 8'd0, 1'b1, dif5[4], dif9[8]};
                    end
                    cra_pkg::ALU_AND: begin
                        alu_res   = a & opnd;
                        new_flags = {(a & opnd) == 8'd0, 1'b0, 1'b1, 1'b0};
                    end
                    cra_pkg::ALU_XOR: begin
                        alu_res   = a ^ opnd;
                        new_flags = {(a ^ opnd) == 8'd0, 3'b000};
                    end
                    default: begin
                        alu_res   = a | opnd;
                        new_flags = {(a | opnd) == 8'd0, 3'b000};
                    end
                endcase
                wr_val = alu_res;
            end
            cra_pkg::K_INC: begin
                wr_flags  = 1'b1;
                wr_val    = inc_val;
                mem_wr    = (i_uop.dst == cra_pkg::IDX_M);
                wr_reg    = !mem_wr;
                mem_wdata = inc_val;
                new_flags = {inc_val == 8'd0, 1'b0, opnd[3:0] == 4'hf, cin};
            end
            cra_pkg::K_DEC: begin
                wr_flags  = 1'b1;
                wr_val    = dec_val;
                mem_wr    = (i_uop.dst == cra_pkg::IDX_M);
                wr_reg    = !mem_wr;
                mem_wdata = dec_val;
                new_flags = {dec_val == 8'd0, 1'b1, opnd[3:0] == 4'h0, cin};
            end
            default: begin
                unsup = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_out.hl_address     = {r_regs[cra_pkg::IDX_H], r_regs[cra_pkg::IDX_L]};
        n_out.mem_write      = mem_wr;
        n_out.mem_write_data = mem_wr ? mem_wdata : 8'd0;
        n_out.accumulator    = (wr_reg && wr_idx == cra_pkg::IDX_A) ? wr_val : a;
        n_out.flags_out      = wr_flags ? new_flags : r_flags;
        n_out.unsupported    = unsup;
    end

    assign o_pop   = i_uop_valid && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_regs[i] <= 8'd0;
            end
            r_flags     <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (wr_reg) begin
                    r_regs[wr_idx] <= wr_val;
                end
                if (wr_flags) begin
                    r_flags <= new_flags;
                end
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- rtl/cpu_register_alu_execute.sv -----
// path: each input beat is decoded, written into the queue, then executed into the output register
// throughput: one opcode per cycle while the queue is not full; register file and flags update in the back end
// a queue of QUEUE_DEPTH entries lets front and back stall independently
// reset (synchronous, active low) clears registers, flags, queue and output valid
module cpu_register_alu_execute #(
    parameter int QUEUE_DEPTH = cra_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  cra_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output cra_pkg::t_out o_data
);

    cra_pkg::t_uop dec_uop, q_uop;
    logic          q_full, q_valid, q_pop;

    assign o_ready = !q_full;

    cra_decode u_decode (
        .i_beat (i_data),
        .o_uop  (dec_uop)
    );

    cra_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_uop   (dec_uop),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_uop   (q_uop)
    );

    cra_exec u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uop_valid (q_valid),
        .i_uop       (q_uop),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

// ----- rtl/cra_checker.sv -----
module cra_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_ready,
    input logic          o_valid,
    input logic          i_ready,
    input cra_pkg::t_out o_data
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("not idle after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output beat changed while stalled");

    a_wdata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.mem_write |-> o_data.mem_write_data == 8'd0)
        else $error("write data without memory write");

    a_unsup_nowr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.unsupported |-> !o_data.mem_write)
        else $error("unsupported opcode wrote memory");

endmodule

bind cpu_register_alu_execute cra_checker u_cra_checker (.*);
